[src/spfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spfs_pkg: shared types and constants for the smallest prime factor sieve
// Table geometry, field widths and the structs passed between the
// sequencer and the top level.
// ---------------------------------------------------------------------------
package spfs_pkg;

  localparam int NUM_W       = 16;
  localparam int TABLE_DEPTH = 65536;
  localparam int INDEX_BITS  = 13;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  // Mark entry: top bit set means marked, low bits hold the prime index
  localparam int MARK_W      = INDEX_BITS + 1;
  localparam int SQ_W        = 2 * NUM_W;
  localparam longint unsigned TABLE_MAX = longint'(TABLE_DEPTH) - 1;

  localparam logic [NUM_W-1:0] LIMIT_RESET = '1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [MARK_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [NUM_W-1:0]      number;
    logic                  is_prime;
    logic [INDEX_BITS-1:0] factor_index;
    logic                  outside_range;
  } result_t;

endpackage
`default_nettype wire

[src/spfs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spfs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module spfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/spfs_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spfs_seq: sieve sequencer
// Clears the mark table after reset, looks up each integer, and for a new
// prime walks its multiples through the one table port pair.
// ---------------------------------------------------------------------------
module spfs_seq (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic [spfs_pkg::NUM_W-1:0]         in_number,
  input  wire logic [spfs_pkg::NUM_W-1:0]         sieve_limit,
  input  wire logic [spfs_pkg::MARK_W-1:0]        rd_data,
  output      spfs_pkg::mem_req_t                 mem_req,
  output      logic                               res_valid,
  output      spfs_pkg::result_t                  res,
  input  wire logic                               res_take
);
  import spfs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_MARK_RD,
    S_MARK_CHK,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [ADDR_W-1:0]     clr_r;
  logic [NUM_W-1:0]      n_r;
  logic [NUM_W-1:0]      lim_r;
  logic [SQ_W-1:0]       m_r;
  logic [INDEX_BITS-1:0] pc_r;
  logic [MARK_W-1:0]     mark_r;
  result_t               res_r;

  logic [NUM_W-1:0] lim_eff;
  logic             in_oor;
  logic             accept;
  logic             rd_marked;

  always_comb begin
    if (longint'(sieve_limit) > longint'(TABLE_MAX)) begin
      lim_eff = NUM_W'(TABLE_MAX);
    end else begin
      lim_eff = sieve_limit;
    end
  end

  assign in_oor    = (in_number < NUM_W'(2)) || (in_number > lim_eff);
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign rd_marked = rd_data[MARK_W-1];
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // table port steering
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = ADDR_W'(n_r);
    mem_req.wdata = mark_r;
    mem_req.raddr = ADDR_W'(in_number);
    unique case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = '0;
      end
      S_LOOKUP: begin
        mem_req.we    = !rd_marked;
        mem_req.wdata = {1'b1, pc_r};
      end
      S_MARK_RD: begin
        mem_req.raddr = ADDR_W'(m_r);
      end
      S_MARK_CHK: begin
        mem_req.we    = !rd_marked;
        mem_req.waddr = ADDR_W'(m_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      pc_r    <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + ADDR_W'(1);
          if (clr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            n_r                <= in_number;
            lim_r              <= lim_eff;
            res_r.number       <= in_number;
            res_r.is_prime     <= 1'b0;
            res_r.factor_index <= '0;
            res_r.outside_range <= in_oor;
            state_r            <= in_oor ? S_DONE : S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (rd_marked) begin
            res_r.factor_index <= rd_data[INDEX_BITS-1:0];
            state_r            <= S_DONE;
          end else begin
            res_r.is_prime     <= 1'b1;
            res_r.factor_index <= pc_r;
            mark_r             <= {1'b1, pc_r};
            if (pc_r != '1) begin
              pc_r <= pc_r + INDEX_BITS'(1);
            end
            m_r     <= SQ_W'(n_r) * SQ_W'(n_r);
            state_r <= S_MARK_RD;
          end
        end
        S_MARK_RD: begin
          // stop once the multiple passes the limit
          state_r <= (m_r > SQ_W'(lim_r)) ? S_DONE : S_MARK_CHK;
        end
        S_MARK_CHK: begin
          m_r     <= m_r + SQ_W'(n_r);
          state_r <= S_MARK_RD;
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_lookup_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP) |-> ($past(state_r) == S_IDLE))
    else $error("lookup not entered from idle");

  a_mark_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK_CHK) |-> (m_r <= SQ_W'(lim_r)))
    else $error("multiple beyond limit checked");

  a_mark_above_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK_CHK) |-> (m_r > SQ_W'(n_r)))
    else $error("multiple not above its prime");

  a_prime_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK_CHK) |-> (pc_r != '0))
    else $error("marking with no prime counted");
`endif

endmodule
`default_nettype wire

[src/smallest_prime_factor_sieve_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// smallest_prime_factor_sieve_unit: smallest prime factor sieve
// Classifies ascending integers, recording the smallest prime index of each.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_number
//   out_     output     out_valid/out_stall number_echo, is_prime,
//                                           factor_index, outside_range
//   cfg_     input      cfg_valid/cfg_ready cfg_sieve_limit
//
// After reset the mark table is cleared, one entry a cycle, with in_stall
// high; cfg writes are taken throughout.
// Out of range items go straight to the result; composites are looked up;
// primes also read, then check, each multiple from the square to the limit on
// the one table port pair. A held result blocks the next item only at completion.
// ---------------------------------------------------------------------------
module smallest_prime_factor_sieve_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [spfs_pkg::NUM_W-1:0]        in_number,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [spfs_pkg::NUM_W-1:0]        out_number_echo,
  output      logic                              out_is_prime,
  output      logic [spfs_pkg::INDEX_BITS-1:0]   out_factor_index,
  output      logic                              out_outside_range,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [spfs_pkg::NUM_W-1:0]        cfg_sieve_limit
);
  import spfs_pkg::*;

  logic [NUM_W-1:0]  limit_r;
  logic [MARK_W-1:0] rd_data;
  mem_req_t          mem_req;
  logic              res_valid;
  result_t           res;
  logic              res_take;
  logic              out_valid_r;
  result_t           out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_sieve_limit;
    end
  end

  spfs_ram #(
    .WIDTH(MARK_W),
    .DEPTH(TABLE_DEPTH)
  ) u_mark_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .raddr(mem_req.raddr),
    .rdata(rd_data)
  );

  spfs_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_number  (in_number),
    .sieve_limit(limit_r),
    .rd_data    (rd_data),
    .mem_req    (mem_req),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  // output register: load when empty or draining this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_number_echo   = out_r.number;
  assign out_is_prime      = out_r.is_prime;
  assign out_factor_index  = out_r.factor_index;
  assign out_outside_range = out_r.outside_range;

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: smallest prime factor sieve unit
// Streams integers through the sieve under several limits, from all out of
// range through the full 16-bit span, and checks every result against a
// local sieve that tracks the mark table, the prime count and the limit.
// The stimulus is mostly ascending runs, with repeats, out of range values
// and stray numbers mixed in. A last run feeds large unmarked integers,
// new primes whose squares lie past the table. Both handshakes idle at
// random, and once the result side holds off long enough to back up the
// input.
// ---------------------------------------------------------------------------
module testbench;
  import spfs_pkg::*;

  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 64;
  localparam int REPORT_LIMIT     = 10;

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [NUM_W-1:0]      in_number       = '0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [NUM_W-1:0]      out_number_echo;
  logic                  out_is_prime;
  logic [INDEX_BITS-1:0] out_factor_index;
  logic                  out_outside_range;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [NUM_W-1:0]      cfg_sieve_limit = '0;

  // local copy of the sieve state
  bit [MARK_W-1:0]     sieve_marks [TABLE_DEPTH];
  bit [INDEX_BITS-1:0] prime_total     = '0;
  bit [NUM_W-1:0]      sieve_limit_now = LIMIT_RESET;

  result_t          predicted_factors [$];
  logic [NUM_W-1:0] pending_numbers [$];
  int               items_pushed   = 0;
  int               items_accepted = 0;
  int               mismatch_count = 0;
  int               next_ascending = 10;
  int               burst_left     = 0;
  int               gap_left       = 0;
  int               stall_mode     = 0;
  int               mode_left      = 0;
  int               hold_left      = 0;
  bit               long_hold_request = 1'b0;
  bit               long_hold_done    = 1'b0;

  smallest_prime_factor_sieve_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_number         (in_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_number_echo   (out_number_echo),
    .out_is_prime      (out_is_prime),
    .out_factor_index  (out_factor_index),
    .out_outside_range (out_outside_range),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_sieve_limit   (cfg_sieve_limit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Classify one integer, update the local sieve, queue the expected result.
  function automatic void classify_number(input logic [NUM_W-1:0] n);
    int unsigned     eff_lim;
    int unsigned     m;
    bit [INDEX_BITS-1:0] idx;
    result_t         r;
    eff_lim = (int'(sieve_limit_now) > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : sieve_limit_now;
    r = '0;
    r.number = n;
    if (n < 2 || n > eff_lim) begin
      r.outside_range = 1'b1;
    end else if (sieve_marks[n] == '0) begin
      idx = prime_total;
      // hold the count at its top value once every index is used
      if (prime_total != '1)
        prime_total = prime_total + INDEX_BITS'(1);
      sieve_marks[n] = MARK_W'(idx) + MARK_W'(1);
      for (m = int'(n) * int'(n); m <= eff_lim; m += int'(n)) begin
        if (sieve_marks[ADDR_W'(m)] == '0)
          sieve_marks[ADDR_W'(m)] = MARK_W'(idx) + MARK_W'(1);
      end
      r.is_prime     = 1'b1;
      r.factor_index = idx;
    end else begin
      r.factor_index = INDEX_BITS'(sieve_marks[n] - MARK_W'(1));
    end
    predicted_factors.insert(predicted_factors.size(), r);
    items_accepted++;
  endfunction

  // Driver: bursts of items with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall)
        classify_number(in_number);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_numbers.size() != 0) begin
          in_valid  <= 1'b1;
          in_number <= pending_numbers.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      mode_left <= 0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold_request && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD_CYCLES - 1;
      out_stall      <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= ($urandom_range(0, 5) == 0) ? ~out_stall : out_stall;
      endcase
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_number_echo, out_is_prime, out_factor_index, out_outside_range};
      if (predicted_factors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: number %0d prime %0b index %0d outside %0b",
                   got.number, got.is_prime, got.factor_index, got.outside_range);
      end else begin
        want = predicted_factors.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"mismatch: expected number %0d prime %0b index %0d outside %0b,",
                      " got number %0d prime %0b index %0d outside %0b"},
                     want.number, want.is_prime, want.factor_index, want.outside_range,
                     got.number, got.is_prime, got.factor_index, got.outside_range);
        end
      end
    end
  end

  task automatic queue_number(input logic [NUM_W-1:0] n);
    pending_numbers.insert(pending_numbers.size(), n);
    items_pushed++;
  endtask

  // Wait until every item is taken, every result is in and the block is ready.
  task automatic wait_idle();
    do @(posedge clk);
    while (items_accepted != items_pushed || predicted_factors.size() != 0 || in_stall);
  endtask

  task automatic write_limit(input logic [NUM_W-1:0] value);
    cfg_valid       <= 1'b1;
    cfg_sieve_limit <= value;
    do @(posedge clk);
    while (!cfg_ready);
    sieve_limit_now = value;
    cfg_valid <= 1'b0;
  endtask

  // Mostly the next ascending integer, with repeats and out of range noise.
  task automatic push_sieve_run(input int count);
    int unsigned pick;
    logic [NUM_W-1:0] n;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        n = NUM_W'(next_ascending);
        next_ascending++;
      end else if (pick < 88) begin
        n = NUM_W'($urandom_range(2, next_ascending - 1));
      end else if (pick < 93 && sieve_limit_now != '1) begin
        n = NUM_W'($urandom_range(int'(sieve_limit_now) + 1, 65535));
      end else if (pick < 97) begin
        n = NUM_W'($urandom_range(0, 1));
      end else begin
        n = NUM_W'($urandom());
      end
      queue_number(n);
    end
  endtask

  initial begin : stimulus
    int main_limit;
    int need;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // limit zero: everything is out of range
    write_limit('0);
    queue_number(16'd0);
    queue_number(16'd1);
    queue_number(16'd2);
    queue_number(16'd3);
    queue_number(16'h5555);
    queue_number(16'hAAAA);
    queue_number(16'hFFFF);
    wait_idle();

    // start of the sieve, edges of the range, repeated composite and prime
    main_limit = $urandom_range(3000, 8000);
    write_limit(NUM_W'(main_limit));
    for (int n = 0; n < 10; n++)
      queue_number(NUM_W'(n));
    queue_number(NUM_W'(main_limit + 1));
    queue_number(16'hFFFF);
    queue_number(16'd9);
    queue_number(16'd7);

    push_sieve_run(300);
    long_hold_request = 1'b1;
    wait_idle();

    write_limit(NUM_W'($urandom_range(1000, 2000)));
    push_sieve_run(300);
    wait_idle();
    write_limit(16'd20000);
    push_sieve_run(300);
    wait_idle();
    write_limit(16'hFFFF);
    push_sieve_run(300);
    wait_idle();

    // lowest useful limit: only 2 is in range
    write_limit(16'd2);
    queue_number(16'd2);
    queue_number(16'd3);
    queue_number(16'd1);
    queue_number(16'd0);
    wait_idle();

    // unmarked integers whose squares lie past the table: each takes a new
    // index and marks nothing beyond itself
    write_limit(16'hFFFF);
    need = 100;
    for (int n = 256; n < 65535 && need > 0; n++) begin
      if (sieve_marks[n] == '0) begin
        queue_number(NUM_W'(n));
        need--;
      end
    end
    queue_number(16'hFFFF);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_factors.size() != 0) begin
      mismatch_count++;
      $display("%0d results never arrived", predicted_factors.size());
    end
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #(64'd20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
